// File: src/sdf_smooth_combine_defines.svh
// Assertion macros for the smooth SDF combine block.
`ifndef SDF_SMOOTH_COMBINE_DEFINES_SVH
`define SDF_SMOOTH_COMBINE_DEFINES_SVH

// same-cycle check, off during reset
`define SDFSC_CHK_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle check, off during reset
`define SDFSC_CHK_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle check, always on
`define SDFSC_CHK_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/sdfsc_pkg.sv
// Types and codes shared by the smooth SDF combine block.
package sdfsc_pkg;

    typedef enum logic [1:0] {
        CMD_UNION = 2'd0,
        CMD_SUB   = 2'd1,
        CMD_INT   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        FC_DIV  = 2'd0,
        FC_ZERO = 2'd1,
        FC_ONE  = 2'd2
    } fcls_t;

    localparam int QBITS = 32;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [33:0] xv;
        logic signed [33:0] yv;
        logic signed [33:0] m;
        logic [3:0][7:0]    ca;
        logic [3:0][7:0]    cb;
        logic signed [32:0] sa;
        logic signed [32:0] na;
        logic               zsum;
        fcls_t              fcls;
        logic signed [33:0] nf;
        logic [32:0]        sf;
        logic [30:0]        k;
        logic [32:0]        k4;
        logic signed [34:0] dxy;
        logic [33:0]        diff;
        logic [32:0]        h;
        logic [33:0]        p00;
        logic [32:0]        p01;
        logic [31:0]        p11;
        logic               hz;
        logic [65:0]        prod;
        logic [34:0]        rem;
        logic [31:0]        q;
        logic [32:0]        remf;
    } item_t;

endpackage

// File: src/sdfsc_div_step.sv
// One registered restoring-division step for the smoothing term and, in steps below FRAC_BITS, the blend fraction.
module sdfsc_div_step #(
    parameter int STEP      = 0,
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  vld_in,
    input  sdfsc_pkg::item_t      it_in,
    input  logic [FRAC_BITS-1:0]  fq_in,
    output logic                  vld_out,
    output sdfsc_pkg::item_t      it_out,
    output logic [FRAC_BITS-1:0]  fq_out
);

    logic                 vld_reg;
    sdfsc_pkg::item_t     it_reg, it_next;
    logic [FRAC_BITS-1:0] fq_reg, fq_next;
    logic [35:0]          t;
    logic [35:0]          dv;
    logic [33:0]          tf;

    always_comb begin
        it_next = it_in;
        fq_next = fq_in;
        dv = {1'b0, it_in.k4, 2'b00};
        t  = {it_in.rem, it_in.prod[sdfsc_pkg::QBITS-1-STEP]};
        if (t >= dv) begin
            it_next.rem = 35'(t - dv);
            it_next.q   = {it_in.q[30:0], 1'b1};
        end else begin
            it_next.rem = t[34:0];
            it_next.q   = {it_in.q[30:0], 1'b0};
        end
        tf = {it_in.remf, 1'b0};
        if (STEP < FRAC_BITS) begin
            if (tf >= {1'b0, it_in.sf}) begin
                it_next.remf = 33'(tf - {1'b0, it_in.sf});
                fq_next      = {fq_in[FRAC_BITS-2:0], 1'b1};
            end else begin
                it_next.remf = tf[32:0];
                fq_next      = {fq_in[FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it_reg <= it_next;
            fq_reg <= fq_next;
        end
    end

    assign vld_out = vld_reg;
    assign it_out  = it_reg;
    assign fq_out  = fq_reg;

endmodule

// File: src/sdf_smooth_combine.sv
// Top level: pipelined polynomial smooth min/sub/intersect of two SDF samples with colour blend.
//
//  channel | dir | handshake         | contents
//  s_      | in  | s_tvalid/s_tready | s_tuser command, s_tdata distances, k, colours
//  m_      | out | m_tvalid/m_tready | m_tdata distance, colour; m_tuser zero-sum flag
//
// One word per cycle sustained while the output is not stalled; 6 front stages, 32 divider
// steps, 3 back stages. The 32-step divider for h*h/(16k) sets the depth.
// aresetn clears all stage valid bits; payload is not reset.
// A stalled output word freezes the whole pipe; s_tready = !m_tvalid | m_tready.
module sdf_smooth_combine #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,  // dist_a, dist_b, smoothness, alpha_a, red_a, green_a,
                                   // blue_a, alpha_b, red_b, green_b, blue_b, zero pad
    input  logic [1:0]   s_tuser,  // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,  // dist_out, alpha_out, red_out, green_out, blue_out
    output logic         m_tuser   // zero_sum_flag
);

    localparam int NFRONT = 6;
    localparam int NDIV   = sdfsc_pkg::QBITS;
    localparam int FW     = FRAC_BITS + 2;
    localparam int PW     = FRAC_BITS + 11;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    sdfsc_pkg::item_t fr_reg [NFRONT];
    sdfsc_pkg::item_t fr_next[NFRONT];
    logic             frv_reg[NFRONT];

    always_comb begin
        logic signed [33:0] a34, b34;
        logic signed [34:0] nd;
        logic signed [33:0] sn;
        fr_next[0] = fr_reg[0];
        for (int i = 1; i < NFRONT; i++) begin
            fr_next[i] = fr_reg[i-1];
        end
        a34 = {{2{s_tdata[31]}}, s_tdata[31:0]};
        b34 = {{2{s_tdata[63]}}, s_tdata[63:32]};
        fr_next[0].cmd = s_tuser;
        fr_next[0].xv  = (s_tuser == sdfsc_pkg::CMD_SUB || s_tuser == sdfsc_pkg::CMD_INT)
                         ? -a34 : a34;
        fr_next[0].yv  = (s_tuser == sdfsc_pkg::CMD_INT) ? -b34 : b34;
        fr_next[0].k   = s_tdata[94:64];
        fr_next[0].na  = a34[32:0];
        fr_next[0].sa  = a34[32:0] + b34[32:0];
        for (int c = 0; c < 4; c++) begin
            fr_next[0].ca[c] = s_tdata[95 + 8*c +: 8];
            fr_next[0].cb[c] = s_tdata[127 + 8*c +: 8];
        end
        // stage 2
        fr_next[1].m    = (fr_reg[0].xv < fr_reg[0].yv) ? fr_reg[0].xv : fr_reg[0].yv;
        fr_next[1].dxy  = {fr_reg[0].xv[33], fr_reg[0].xv} - {fr_reg[0].yv[33], fr_reg[0].yv};
        fr_next[1].k4   = {fr_reg[0].k, 2'b00};
        fr_next[1].zsum = (fr_reg[0].sa == 33'sd0);
        sn = -{fr_reg[0].sa[32], fr_reg[0].sa};
        if (fr_reg[0].sa[32]) begin
            fr_next[1].sf = sn[32:0];
            fr_next[1].nf = -{fr_reg[0].na[32], fr_reg[0].na};
        end else begin
            fr_next[1].sf = fr_reg[0].sa;
            fr_next[1].nf = {fr_reg[0].na[32], fr_reg[0].na};
        end
        // stage 3
        nd = -fr_reg[1].dxy;
        fr_next[2].diff = fr_reg[1].dxy[34] ? nd[33:0] : fr_reg[1].dxy[33:0];
        if (fr_reg[1].zsum || fr_reg[1].nf[33] || fr_reg[1].nf == 34'sd0) begin
            fr_next[2].fcls = sdfsc_pkg::FC_ZERO;
        end else if (fr_reg[1].nf[32:0] >= fr_reg[1].sf) begin
            fr_next[2].fcls = sdfsc_pkg::FC_ONE;
        end else begin
            fr_next[2].fcls = sdfsc_pkg::FC_DIV;
        end
        fr_next[2].remf = fr_reg[1].nf[32:0];
        // stage 4
        if ({1'b0, fr_reg[2].k4} > fr_reg[2].diff) begin
            fr_next[3].h = 33'({1'b0, fr_reg[2].k4} - fr_reg[2].diff);
        end else begin
            fr_next[3].h = '0;
        end
        // stage 5
        fr_next[4].p00 = fr_reg[3].h[16:0] * fr_reg[3].h[16:0];
        fr_next[4].p01 = fr_reg[3].h[16:0] * fr_reg[3].h[32:17];
        fr_next[4].p11 = fr_reg[3].h[32:17] * fr_reg[3].h[32:17];
        fr_next[4].hz  = (fr_reg[3].h == 33'd0);
        // stage 6
        fr_next[5].prod = {32'd0, fr_reg[4].p00} + {15'd0, fr_reg[4].p01, 18'd0}
                          + {fr_reg[4].p11, 34'd0};
        fr_next[5].rem  = {1'b0, fr_next[5].prod[65:32]};
        fr_next[5].q    = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NFRONT; i++) frv_reg[i] <= 1'b0;
        end else if (en) begin
            frv_reg[0] <= s_tvalid;
            for (int i = 1; i < NFRONT; i++) frv_reg[i] <= frv_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NFRONT; i++) fr_reg[i] <= fr_next[i];
        end
    end

    logic                 dv   [NDIV+1];
    sdfsc_pkg::item_t     dit  [NDIV+1];
    logic [FRAC_BITS-1:0] dfq  [NDIV+1];

    assign dv[0]  = frv_reg[NFRONT-1];
    assign dit[0] = fr_reg[NFRONT-1];
    assign dfq[0] = '0;

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        sdfsc_div_step #(
            .STEP      (g),
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .vld_in  (dv[g]),
            .it_in   (dit[g]),
            .fq_in   (dfq[g]),
            .vld_out (dv[g+1]),
            .it_out  (dit[g+1]),
            .fq_out  (dfq[g+1])
        );
    end

    // back stages
    logic                 b1v_reg, b2v_reg, ov_reg;
    logic signed [35:0]   b1d_reg, b1d_next;
    logic signed [FW-1:0] b1f_reg, b1f_next;
    logic [1:0]           b1c_reg, b2c_reg;
    logic                 b1z_reg, b2z_reg;
    logic [3:0][7:0]      b1ca_reg, b1cb_reg, b2ca_reg;
    logic [31:0]          b2d_reg, b2d_next;
    logic signed [PW-1:0] b2p_reg [4];
    logic signed [PW-1:0] b2p_next[4];
    logic [63:0]          od_reg, od_next;
    logic                 ou_reg, ou_next;

    always_comb begin
        sdfsc_pkg::item_t   it;
        logic signed [34:0] dsm;
        it  = dit[NDIV];
        dsm = {it.m[33], it.m} - (it.hz ? 35'sd0 : $signed({3'b000, it.q}));
        if (it.cmd == sdfsc_pkg::CMD_SUB || it.cmd == sdfsc_pkg::CMD_INT) begin
            b1d_next = -{dsm[34], dsm};
        end else begin
            b1d_next = {dsm[34], dsm};
        end
        case (it.fcls)
            sdfsc_pkg::FC_ONE:  b1f_next = FW'(1) <<< FRAC_BITS;
            sdfsc_pkg::FC_DIV:  b1f_next = $signed({2'b00, dfq[NDIV]});
            default:            b1f_next = '0;
        endcase
        if (it.cmd == sdfsc_pkg::CMD_SUB) b1f_next = '0;
    end

    always_comb begin
        logic signed [8:0] dc;
        if (b1d_reg > 36'sh07FFFFFFF) begin
            b2d_next = 32'h7FFFFFFF;
        end else if (b1d_reg < -36'sh080000000) begin
            b2d_next = 32'h80000000;
        end else begin
            b2d_next = b1d_reg[31:0];
        end
        for (int c = 0; c < 4; c++) begin
            dc = $signed({1'b0, b1cb_reg[c]}) - $signed({1'b0, b1ca_reg[c]});
            b2p_next[c] = PW'(dc) * PW'(b1f_reg);
        end
    end

    always_comb begin
        logic signed [PW:0] np;
        logic signed [PW:0] qv;
        np = '0;
        od_next[31:0] = b2d_reg;
        for (int c = 0; c < 4; c++) begin
            if (!b2p_reg[c][PW-1]) begin
                qv = {b2p_reg[c][PW-1], b2p_reg[c]} >>> FRAC_BITS;
            end else begin
                np = -{b2p_reg[c][PW-1], b2p_reg[c]} + ((PW+1)'(1) <<< FRAC_BITS) - 1;
                qv = -(np >>> FRAC_BITS);
            end
            od_next[32 + 8*c +: 8] = b2ca_reg[c] + qv[7:0];
        end
        ou_next = (b2c_reg == sdfsc_pkg::CMD_SUB) ? 1'b0 : b2z_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1v_reg <= 1'b0;
            b2v_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end else if (en) begin
            b1v_reg <= dv[NDIV];
            b2v_reg <= b1v_reg;
            ov_reg  <= b2v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b1d_reg  <= b1d_next;
            b1f_reg  <= b1f_next;
            b1c_reg  <= dit[NDIV].cmd;
            b1z_reg  <= dit[NDIV].zsum;
            b1ca_reg <= dit[NDIV].ca;
            b1cb_reg <= dit[NDIV].cb;
            b2d_reg  <= b2d_next;
            for (int c = 0; c < 4; c++) b2p_reg[c] <= b2p_next[c];
            b2c_reg  <= b1c_reg;
            b2z_reg  <= b1z_reg;
            b2ca_reg <= b1ca_reg;
            od_reg   <= od_next;
            ou_reg   <= ou_next;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ou_reg;

endmodule

// File: src/sdfsc_checker.sv
// Port-level checks for the smooth SDF combine block, bound to the top level.
`include "sdf_smooth_combine_defines.svh"

module sdfsc_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic         m_tuser
);

    `SDFSC_CHK_RST(a_rst_empty, !aresetn, !m_tvalid, "output valid after reset")
    `SDFSC_CHK_NOW(a_ready_rule, 1'b1, s_tready == (!m_tvalid || m_tready), "input ready mismatch")
    `SDFSC_CHK_NXT(a_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled output word changed")

endmodule

bind sdf_smooth_combine sdfsc_checker u_sdfsc_checker (.*);
